@@ rtl/fsq_pkg.sv @@
// package for the four-sum quadruple finder: sizes, payload types, states
package fsq_pkg;

  localparam int unsigned MaxElems = 64;
  localparam int unsigned MaxOut   = 64;
  localparam int unsigned IdxW     = $clog2(MaxElems);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned OutAW    = (MaxOut > 1) ? $clog2(MaxOut) : 1;
  localparam int unsigned OutCntW  = $clog2(MaxOut + 1);
  localparam int unsigned QuadW    = 128;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] first_value;
    logic signed [31:0] second_value;
    logic signed [31:0] third_value;
    logic signed [31:0] fourth_value;
    logic               found;
    logic               last_result;
    logic               truncated;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRT_RD,
    ST_SRT_KEY,
    ST_SRT_P,
    ST_SRT_CMP,
    ST_I_RD,
    ST_I_CHK,
    ST_J_RD,
    ST_J_CHK,
    ST_K_RD,
    ST_K_CHK,
    ST_X,
    ST_B_RD,
    ST_B_CHK,
    ST_HIT,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

endpackage

@@ rtl/fsq_ram.sv @@
// generic single-write, single-read ram with registered read data
module fsq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/four_sum_quadruple_finder.sv @@
// top level of the four-sum quadruple finder
//
// usage:
//  - target_sum is written through cfg_we_i / cfg_data_i while the block is idle
//  - values come in on in_i, one transfer per cycle when start_i is high and
//    busy_o is low; the store holds 64 values, more are dropped and flagged
//  - a transfer with last set raises busy_o; the stored values are insertion
//    sorted in the element ram by read-modify-write steps
//  - the search walks the triples with a binary search in the sorted tail,
//    reading through the element ram port; found quadruples
//    are kept in the quad ram until the search ends, since truncated must be
//    known on the first result
//  - results then leave one at a time, never back to back, each on result_o for one cycle
//    with result_valid_o; an empty answer gives a single result with found=0
//  - busy_o falls with the final result, when the data set is cleared and the
//    next transfer starts a new one
//  - the receiver cannot stall: every result strobe is a completed transfer
//  - reset clears the counters, the dropped flag and target_sum; ram
//    contents are never cleared, only written entries are read
module four_sum_quadruple_finder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fsq_pkg::in_item_t in_i,
  output logic              busy_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i,
  output logic              result_valid_o,
  output fsq_pkg::result_t  result_o
);

  fsq_pkg::state_e state_q, state_d;

  logic [31:0]                  target_q;
  logic [fsq_pkg::CntW-1:0]     count_q, count_d;
  logic                         drop_q, drop_d;
  logic [fsq_pkg::CntW-1:0]     i_q, i_d, j_q, j_d, k_q, k_d, p_q, p_d;
  logic [fsq_pkg::CntW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0]                  key_q, key_d, vi_q, vi_d, vj_q, vj_d, vk_q, vk_d;
  logic [31:0]                  x_q, x_d;
  logic [fsq_pkg::OutCntW-1:0]  got_q, got_d, r_q, r_d;
  logic                         more_q, more_d;
  logic                         valid_q, valid_d;
  fsq_pkg::result_t             res_q, res_d;

  logic                         e_we;
  logic [fsq_pkg::IdxW-1:0]     e_waddr, e_raddr;
  logic [31:0]                  e_wdata, e_rdata;
  logic                         q_we;
  logic [fsq_pkg::QuadW-1:0]    q_rdata;
  logic [fsq_pkg::OutAW-1:0]    q_raddr;

  logic                         accept;
  logic [fsq_pkg::CntW:0]       mid_sum;
  logic [fsq_pkg::CntW-1:0]     mid;
  logic [34:0]                  xw;
  logic                         x_ok, skip_i, skip_j, skip_k, bigger;

  assign accept  = start_i && !busy_o;
  assign busy_o  = (state_q != fsq_pkg::ST_IDLE);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[fsq_pkg::CntW:1];
  assign xw      = {{3{target_q[31]}}, target_q}
                 - ({{3{vi_q[31]}}, vi_q} + {{3{vj_q[31]}}, vj_q} + {{3{vk_q[31]}}, vk_q});
  assign x_ok    = (xw[34:31] == 4'b0000) || (xw[34:31] == 4'b1111);
  assign skip_i  = (i_q != '0) && (e_rdata == vi_q);
  assign skip_j  = (j_q != i_q + 1'b1) && (e_rdata == vj_q);
  assign skip_k  = (k_q != j_q + 1'b1) && (e_rdata == vk_q);
  assign bigger  = $signed(e_rdata) > $signed(key_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fsq_pkg::ST_IDLE:    if (accept && in_i.last) state_d = fsq_pkg::ST_SRT_RD;
      fsq_pkg::ST_SRT_RD:  state_d = (i_q >= count_q) ? fsq_pkg::ST_I_RD : fsq_pkg::ST_SRT_KEY;
      fsq_pkg::ST_SRT_KEY: state_d = fsq_pkg::ST_SRT_P;
      fsq_pkg::ST_SRT_P:   state_d = (p_q == '0) ? fsq_pkg::ST_SRT_RD : fsq_pkg::ST_SRT_CMP;
      fsq_pkg::ST_SRT_CMP: state_d = bigger ? fsq_pkg::ST_SRT_P : fsq_pkg::ST_SRT_RD;
      fsq_pkg::ST_I_RD:    state_d = (i_q >= count_q) ? fsq_pkg::ST_EMIT_RD : fsq_pkg::ST_I_CHK;
      fsq_pkg::ST_I_CHK:   state_d = skip_i ? fsq_pkg::ST_I_RD : fsq_pkg::ST_J_RD;
      fsq_pkg::ST_J_RD:    state_d = (j_q >= count_q) ? fsq_pkg::ST_I_RD : fsq_pkg::ST_J_CHK;
      fsq_pkg::ST_J_CHK:   state_d = skip_j ? fsq_pkg::ST_J_RD : fsq_pkg::ST_K_RD;
      fsq_pkg::ST_K_RD:    state_d = (k_q >= count_q) ? fsq_pkg::ST_J_RD : fsq_pkg::ST_K_CHK;
      fsq_pkg::ST_K_CHK:   state_d = skip_k ? fsq_pkg::ST_K_RD : fsq_pkg::ST_X;
      fsq_pkg::ST_X:       state_d = x_ok ? fsq_pkg::ST_B_RD : fsq_pkg::ST_K_RD;
      fsq_pkg::ST_B_RD:    state_d = (lo_q >= hi_q) ? fsq_pkg::ST_K_RD : fsq_pkg::ST_B_CHK;
      fsq_pkg::ST_B_CHK:   state_d = (e_rdata == x_q) ? fsq_pkg::ST_HIT : fsq_pkg::ST_B_RD;
      fsq_pkg::ST_HIT: begin
        state_d = (got_q < fsq_pkg::OutCntW'(fsq_pkg::MaxOut)) ? fsq_pkg::ST_K_RD
                                                               : fsq_pkg::ST_EMIT_RD;
      end
      fsq_pkg::ST_EMIT_RD: state_d = (got_q == '0) ? fsq_pkg::ST_IDLE : fsq_pkg::ST_EMIT_OUT;
      fsq_pkg::ST_EMIT_OUT: begin
        state_d = (r_q == got_q - 1'b1) ? fsq_pkg::ST_IDLE : fsq_pkg::ST_EMIT_RD;
      end
      default:             state_d = fsq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d = count_q; drop_d = drop_q;
    i_d = i_q; j_d = j_q; k_d = k_q; p_d = p_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    key_d = key_q; vi_d = vi_q; vj_d = vj_q; vk_d = vk_q; x_d = x_q;
    got_d = got_q; r_d = r_q; more_d = more_q;
    valid_d = 1'b0; res_d = res_q;
    e_we = 1'b0; e_waddr = p_q[fsq_pkg::IdxW-1:0]; e_wdata = key_q;
    e_raddr = i_q[fsq_pkg::IdxW-1:0];
    q_we = 1'b0; q_raddr = r_q[fsq_pkg::OutAW-1:0];
    case (state_q)
      fsq_pkg::ST_IDLE: begin
        if (accept) begin
          if (count_q < fsq_pkg::CntW'(fsq_pkg::MaxElems)) begin
            e_we    = 1'b1;
            e_waddr = count_q[fsq_pkg::IdxW-1:0];
            e_wdata = in_i.value;
            count_d = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          i_d = fsq_pkg::CntW'(1);
        end
      end
      fsq_pkg::ST_SRT_RD: begin
        if (i_q >= count_q) begin
          i_d = '0; got_d = '0; more_d = 1'b0;
        end
      end
      fsq_pkg::ST_SRT_KEY: begin
        key_d = e_rdata;
        p_d   = i_q;
      end
      fsq_pkg::ST_SRT_P: begin
        if (p_q == '0) begin
          e_we = 1'b1;
          i_d  = i_q + 1'b1;
        end else begin
          e_raddr = p_q[fsq_pkg::IdxW-1:0] - 1'b1;
        end
      end
      fsq_pkg::ST_SRT_CMP: begin
        // shift the larger neighbor up, or drop the key into its slot
        e_we = 1'b1;
        if (bigger) begin
          e_wdata = e_rdata;
          p_d     = p_q - 1'b1;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      fsq_pkg::ST_I_RD: begin
        r_d = '0;
      end
      fsq_pkg::ST_I_CHK: begin
        if (skip_i) begin
          i_d = i_q + 1'b1;
        end else begin
          vi_d = e_rdata;
          j_d  = i_q + 1'b1;
        end
      end
      fsq_pkg::ST_J_RD: begin
        e_raddr = j_q[fsq_pkg::IdxW-1:0];
        if (j_q >= count_q) i_d = i_q + 1'b1;
      end
      fsq_pkg::ST_J_CHK: begin
        if (skip_j) begin
          j_d = j_q + 1'b1;
        end else begin
          vj_d = e_rdata;
          k_d  = j_q + 1'b1;
        end
      end
      fsq_pkg::ST_K_RD: begin
        e_raddr = k_q[fsq_pkg::IdxW-1:0];
        if (k_q >= count_q) j_d = j_q + 1'b1;
      end
      fsq_pkg::ST_K_CHK: begin
        if (skip_k) k_d = k_q + 1'b1;
        else        vk_d = e_rdata;
      end
      fsq_pkg::ST_X: begin
        x_d  = xw[31:0];
        lo_d = k_q + 1'b1;
        hi_d = count_q;
        if (!x_ok) k_d = k_q + 1'b1;
      end
      fsq_pkg::ST_B_RD: begin
        e_raddr = mid[fsq_pkg::IdxW-1:0];
        mid_d   = mid;
        if (lo_q >= hi_q) k_d = k_q + 1'b1;
      end
      fsq_pkg::ST_B_CHK: begin
        if ($signed(e_rdata) < $signed(x_q)) lo_d = mid_q + 1'b1;
        else                                 hi_d = mid_q;
      end
      fsq_pkg::ST_HIT: begin
        if (got_q < fsq_pkg::OutCntW'(fsq_pkg::MaxOut)) begin
          q_we  = 1'b1;
          got_d = got_q + 1'b1;
          k_d   = k_q + 1'b1;
        end else begin
          more_d = 1'b1;
        end
      end
      fsq_pkg::ST_EMIT_RD: begin
        if (got_q == '0) begin
          valid_d           = 1'b1;
          res_d             = '0;
          res_d.last_result = 1'b1;
          res_d.truncated   = drop_q | more_q;
          count_d = '0; drop_d = 1'b0;
        end
      end
      fsq_pkg::ST_EMIT_OUT: begin
        valid_d            = 1'b1;
        res_d.first_value  = q_rdata[127:96];
        res_d.second_value = q_rdata[95:64];
        res_d.third_value  = q_rdata[63:32];
        res_d.fourth_value = q_rdata[31:0];
        res_d.found        = 1'b1;
        res_d.last_result  = (r_q == got_q - 1'b1);
        res_d.truncated    = drop_q | more_q;
        r_d                = r_q + 1'b1;
        if (r_q == got_q - 1'b1) begin
          count_d = '0; drop_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fsq_pkg::ST_IDLE;
      target_q <= '0;
      count_q  <= '0;
      drop_q   <= 1'b0;
      got_q    <= '0;
      r_q      <= '0;
      more_q   <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) target_q <= cfg_data_i;
      count_q <= count_d;
      drop_q  <= drop_d;
      got_q   <= got_d;
      r_q     <= r_d;
      more_q  <= more_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; k_q <= k_d; p_q <= p_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    key_q <= key_d; vi_q <= vi_d; vj_q <= vj_d; vk_q <= vk_d; x_q <= x_d;
    res_q <= res_d;
  end

  fsq_ram #(.Width(32), .Depth(fsq_pkg::MaxElems)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  fsq_ram #(.Width(fsq_pkg::QuadW), .Depth(fsq_pkg::MaxOut)) u_quad_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (got_q[fsq_pkg::OutAW-1:0]),
    .wdata_i ({vi_q, vj_q, vk_q, x_q}),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

@@ rtl/fsq_checker.sv @@
// port-level checker for the four-sum quadruple finder, bound to the top level
module fsq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input fsq_pkg::in_item_t in_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input fsq_pkg::result_t  result_o
);

  // a last transfer starts the search
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.last |=> busy_o) else $error("no search after last");

  // an empty answer is always the only result
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.found |-> result_o.last_result)
    else $error("empty result not final");

  // more results pending keeps the block busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_result |-> busy_o) else $error("idle mid answer");

  // the final result frees the block
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_result |-> !busy_o) else $error("busy after answer");

  // results of one answer never come back to back
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_result |=> !result_valid_o)
    else $error("results back to back");

endmodule

bind four_sum_quadruple_finder fsq_checker u_fsq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .in_i           (in_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

@@ dv/four_sum_quadruple_finder_tb.sv @@
// testbench for the four-sum quadruple finder: random data sets checked against a predictor
module four_sum_quadruple_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsWanted = 500;
  localparam longint      IntMin      = -64'sd2147483648;
  localparam longint      IntMax      = 64'sd2147483647;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  fsq_pkg::in_item_t         in_i;
  logic                      busy_o;
  logic                      cfg_we_i;
  logic [31:0]               cfg_data_i;
  logic                      result_valid_o;
  fsq_pkg::result_t          result_o;

  four_sum_quadruple_finder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_i           (in_i),
    .busy_o         (busy_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // predictor state
  longint                set_vals[fsq_pkg::MaxElems];
  int unsigned           set_count;
  bit                    set_dropped;
  longint                target_sum;
  fsq_pkg::result_t      quad_q[$];
  fsq_pkg::in_item_t     pending_q[$];

  int unsigned   items_sent;
  int unsigned   answers_seen;
  int unsigned   quads_seen;
  int unsigned   mismatches;
  int unsigned   gap_cnt;
  bit            no_gaps;

  // sort the set, walk the triples and queue up to MaxOut quadruples it yields, or an empty result
  function automatic void search_set();
    longint            s[fsq_pkg::MaxElems];
    longint            key;
    longint            x;
    int                p;
    int                lo;
    int                hi;
    int                mid;
    int                n;
    int                got;
    bit                more;
    bit                hit;
    fsq_pkg::result_t  res;
    fsq_pkg::result_t  found_q[$];
    n = set_count;
    for (int a = 0; a < n; a++) s[a] = set_vals[a];
    for (int a = 1; a < n; a++) begin
      key = s[a];
      p = a;
      while (p > 0 && s[p-1] > key) begin
        s[p] = s[p-1];
        p--;
      end
      s[p] = key;
    end
    got = 0;
    more = 1'b0;
    for (int i = 0; i < n && !more; i++) begin
      if (i > 0 && s[i] == s[i-1]) continue;
      for (int j = i + 1; j < n && !more; j++) begin
        if (j > i + 1 && s[j] == s[j-1]) continue;
        for (int k = j + 1; k < n && !more; k++) begin
          if (k > j + 1 && s[k] == s[k-1]) continue;
          x = target_sum - (s[i] + s[j] + s[k]);
          if (x < IntMin || x > IntMax) continue;
          lo = k + 1;
          hi = n;
          hit = 1'b0;
          while (lo < hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (s[mid] == x) hit = 1'b1;
            else if (s[mid] < x) lo = mid + 1;
            else hi = mid;
          end
          if (!hit) continue;
          if (got < fsq_pkg::MaxOut) begin
            res = '0;
            res.first_value  = s[i][31:0];
            res.second_value = s[j][31:0];
            res.third_value  = s[k][31:0];
            res.fourth_value = x[31:0];
            res.found        = 1'b1;
            found_q = {found_q, res};
            got++;
          end else begin
            more = 1'b1;
          end
        end
      end
    end
    if (got == 0) begin
      res = '0;
      res.last_result = 1'b1;
      res.truncated   = set_dropped;
      quad_q = {quad_q, res};
    end else begin
      foreach (found_q[r]) begin
        found_q[r].last_result = (r == got - 1);
        found_q[r].truncated   = set_dropped | more;
        quad_q = {quad_q, found_q[r]};
      end
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic void load_value(fsq_pkg::in_item_t it);
    if (set_count < fsq_pkg::MaxElems) begin
      set_vals[set_count] = longint'(it.value);
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.last) search_set();
  endfunction

  // driver: one transfer per accepting edge, with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      in_i    <= '0;
      gap_cnt <= 0;
    end else begin
      if (start_i && !busy_o) begin
        load_value(in_i);
        items_sent <= items_sent + 1;
      end
      if (!start_i || !busy_o) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          start_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_i    <= pending_q.pop_front();
          start_i <= 1'b1;
          if (!no_gaps && $urandom_range(0, 4) == 0) gap_cnt <= $urandom_range(1, 5);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is a completed result transfer
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (quad_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", result_o);
      end else begin
        if (result_o !== quad_q[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("result mismatch: expected %p, got %p", quad_q[0], result_o);
          end
        end
        if (quad_q[0].found) quads_seen <= quads_seen + 1;
        if (quad_q[0].last_result) answers_seen <= answers_seen + 1;
        void'(quad_q.pop_front());
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || quad_q.size() > 0 || start_i || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_target(longint v);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v[31:0];
    @(posedge clk_i);
    target_sum = longint'(signed'(v[31:0]));
    cfg_we_i   <= 1'b0;
  endtask

  task automatic push_value(longint v, bit lst);
    fsq_pkg::in_item_t it;
    it.value = v[31:0];
    it.last  = lst;
    pending_q = {pending_q, it};
  endtask

  // values drawn per mode: 0 small, 1 full range, 2 near the extremes
  function automatic longint pick_value(int mode);
    case (mode)
      0: return longint'($urandom_range(0, 12)) - 6;
      1: return longint'(signed'($urandom));
      default: return ($urandom_range(0, 1) ? IntMax : IntMin) +
                      ($urandom_range(0, 1) ? -longint'($urandom_range(0, 2))
                                             : longint'($urandom_range(0, 2)));
    endcase
  endfunction

  initial begin
    int          n;
    int          mode;
    longint      t;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    set_count    = 0;
    set_dropped  = 1'b0;
    target_sum   = 0;
    items_sent   = 0;
    answers_seen = 0;
    quads_seen   = 0;
    mismatches   = 0;
    no_gaps      = 1'b0;
    rst_ni       = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // classic set at target zero after reset
    push_value(1, 0); push_value(0, 0); push_value(-1, 0);
    push_value(0, 0); push_value(-2, 0); push_value(2, 1);
    // single value, then three values: no quadruple possible
    wait_idle();
    push_value(5, 1);
    wait_idle();
    push_value(0, 0); push_value(0, 0); push_value(0, 1);
    // remainder out of 32-bit range
    write_target(IntMax);
    push_value(IntMin, 0); push_value(IntMin, 0); push_value(IntMin, 0);
    push_value(IntMax, 1);
    write_target(IntMin);
    push_value(IntMin, 0); push_value(0, 0); push_value(0, 0);
    push_value(0, 0); push_value(IntMax, 0); push_value(-1, 1);
    // more quadruples than the output cap
    write_target(38);
    for (int v = 0; v < 20; v++) push_value(v, v == 19);
    // store overflow: values beyond capacity are dropped and flagged
    write_target(0);
    for (int v = 0; v < 70; v++) push_value((v % 9) - 4, v == 69);

    while (items_sent + pending_q.size() < ItemsWanted) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: t = longint'($urandom_range(0, 20)) - 10;
          1: t = IntMin;
          2: t = IntMax;
          default: t = longint'(signed'($urandom));
        endcase
        write_target(t);
      end else begin
        wait_idle();
      end
      if (items_sent + pending_q.size() > ItemsWanted - 50) no_gaps = 1'b1;
      n = ($urandom_range(0, 60) == 0) ? $urandom_range(64, 68) : $urandom_range(1, 10);
      mode = ($urandom_range(0, 5) < 4) ? 0 : $urandom_range(1, 2);
      for (int a = 0; a < n; a++) push_value(pick_value(mode), a == n - 1);
    end

    no_gaps = 1'b1;
    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("sent %0d values, checked %0d answers carrying %0d quadruples",
             items_sent, answers_seen, quads_seen);
    if (mismatches == 0 && quad_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, quad_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
